>>> design/assert_macros.svh
// assertion macros shared by the sort and classify rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tksc_pkg.sv
// shared types and constants of the two-key sort and classify block
// no dependencies
`default_nettype none

package tksc_pkg;

  localparam int TKSC_MAX_RECORDS  = 64;
  localparam int TKSC_ENERGY_WIDTH = 32;

  localparam int ENERGY_IN_W = 32;
  localparam int KIND_W      = 3;
  localparam int KIND_PAIR_W = 2 * KIND_W;
  localparam int IDX_W       = 6;
  localparam int CLASS_W     = 2;

  localparam logic [KIND_W-1:0] KIND_A    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_B    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_C    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_D    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NONE = 3'd4;

  localparam logic [CLASS_W-1:0] CLASS_AA    = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_BB    = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_OTHER = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_ERROR = 2'd3;

  typedef struct packed {
    logic accept;
    logic ord_rd;
    logic rec_rd;
    logic shift;
    logic place;
    logic em_ord_rd;
    logic em_kind_rd;
    logic out_load;
    logic next_item;
    logic run_done;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic count_zero;
    logic pos_one;
    logic new_first;
    logic in_last;
    logic last;
    logic out_busy;
    logic out_taken;
    logic run_end;
  } status_t;

endpackage

`default_nettype wire

>>> design/tksc_if.sv
// word channels of the sort block: record input and result output
// depends on tksc_pkg
`default_nettype none

interface tksc_rec_if import tksc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ENERGY_IN_W-1:0] upper_energy;
  logic [ENERGY_IN_W-1:0] lower_energy;
  logic [KIND_W-1:0]      upper_kind;
  logic [KIND_W-1:0]      lower_kind;
  logic                   last;

  modport source (output valid, upper_energy, lower_energy, upper_kind, lower_kind, last,
                  input ready);
  modport sink   (input valid, upper_energy, lower_energy, upper_kind, lower_kind, last,
                  output ready);
endinterface

interface tksc_res_if import tksc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   record_index;
  logic [CLASS_W-1:0] pair_class;
  logic               run_end;

  modport source (output valid, record_index, pair_class, run_end, input ready);
  modport sink   (input valid, record_index, pair_class, run_end, output ready);
endinterface

`default_nettype wire

>>> design/tksc_ctrl.sv
// controller of the sort block: insertion walk and emission sequencing
// depends on tksc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tksc_ctrl import tksc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_ORD     = 9'b000000010,
    ST_REC     = 9'b000000100,
    ST_CMP     = 9'b000001000,
    ST_PLACE   = 9'b000010000,
    ST_EM_ORD  = 9'b000100000,
    ST_EM_KIND = 9'b001000000,
    ST_EM_OUT  = 9'b010000000,
    ST_EM_WAIT = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.full) begin
            state_nxt = st.in_last ? ST_EM_ORD : ST_IDLE;
          end else if (st.count_zero) begin
            state_nxt = ST_PLACE;
          end else begin
            state_nxt = ST_ORD;
          end
        end
      end
      ST_ORD: begin
        cmd.ord_rd = 1'b1;
        state_nxt  = ST_REC;
      end
      ST_REC: begin
        cmd.rec_rd = 1'b1;
        state_nxt  = ST_CMP;
      end
      ST_CMP: begin
        if (st.new_first) begin
          cmd.shift = 1'b1;
          state_nxt = st.pos_one ? ST_PLACE : ST_ORD;
        end else begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = st.last ? ST_EM_ORD : ST_IDLE;
      end
      ST_EM_ORD: begin
        cmd.em_ord_rd = 1'b1;
        state_nxt     = ST_EM_KIND;
      end
      ST_EM_KIND: begin
        cmd.em_kind_rd = 1'b1;
        state_nxt      = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_EM_WAIT;
      end
      ST_EM_WAIT: begin
        if (st.out_taken) begin
          if (st.run_end) begin
            cmd.run_done = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            cmd.next_item = 1'b1;
            state_nxt     = ST_EM_ORD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_IMPL(a_ready_no_pending, clk, rst_n, in_ready, !st.out_busy,
               "input ready with result pending")
  `ASSERT_NEXT(a_done_to_idle, clk, rst_n, cmd.run_done, in_ready && !st.out_busy,
               "run end not back to idle")

endmodule

`default_nettype wire

>>> design/tksc_dp.sv
// datapath of the sort block: record stores, order list, compare and result register
// depends on tksc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tksc_dp import tksc_pkg::*; #(
  parameter int MAX_RECORDS  = TKSC_MAX_RECORDS,
  parameter int ENERGY_WIDTH = TKSC_ENERGY_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmd_t                   cmd,
  output status_t                     st,
  input  wire logic [ENERGY_IN_W-1:0] in_upper_energy,
  input  wire logic [ENERGY_IN_W-1:0] in_lower_energy,
  input  wire logic [KIND_W-1:0]      in_upper_kind,
  input  wire logic [KIND_W-1:0]      in_lower_kind,
  input  wire logic                   in_last,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [IDX_W-1:0]            out_record_index,
  output logic [CLASS_W-1:0]          out_pair_class,
  output logic                        out_run_end
);

  localparam int IW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int EW = ENERGY_WIDTH;

  logic [EW-1:0]          ue_mem   [MAX_RECORDS];
  logic [EW-1:0]          le_mem   [MAX_RECORDS];
  logic [KIND_PAIR_W-1:0] kind_mem [MAX_RECORDS];
  logic [IW-1:0]          ord_mem  [MAX_RECORDS];

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic          last_r, last_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [EW-1:0]          new_ue_r, new_le_r, ue_q_r, le_q_r;
  logic [IW-1:0]          new_idx_r, ord_q_r;
  logic [KIND_PAIR_W-1:0] kind_q_r;
  logic [IDX_W-1:0]       out_idx_r;
  logic [CLASS_W-1:0]     out_class_r;
  logic                   out_end_r;

  logic [EW+ENERGY_IN_W-1:0] ue_ext, le_ext;
  logic [EW-1:0]             ue_in, le_in;
  logic [IW-1:0]             wr_idx, ord_ra, ord_wa, ord_wd;
  logic [CW-1:0]             pos_dec, k_cnt;
  logic [IW+IDX_W-1:0]       idx_ext;
  logic [CLASS_W-1:0]        cls;
  logic                      full, final_item;

  function automatic logic [CLASS_W-1:0] classify(input logic [KIND_PAIR_W-1:0] kinds);
    logic [KIND_W-1:0] up;
    logic [KIND_W-1:0] lo;
    up = kinds[KIND_W-1:0];
    lo = kinds[KIND_PAIR_W-1:KIND_W];
    if (up >= KIND_NONE || lo >= KIND_NONE) begin
      return CLASS_ERROR;
    end else if (up == KIND_A && lo == KIND_A) begin
      return CLASS_AA;
    end else if (up == KIND_B && lo == KIND_B) begin
      return CLASS_BB;
    end
    return CLASS_OTHER;
  endfunction

  // energies narrowed or zero-extended to the stored width
  assign ue_ext = {{EW{1'b0}}, in_upper_energy};
  assign le_ext = {{EW{1'b0}}, in_lower_energy};
  assign ue_in  = ue_ext[EW-1:0];
  assign le_in  = le_ext[EW-1:0];

  assign full    = (count_r == CW'(MAX_RECORDS));
  assign wr_idx  = count_r[IW-1:0];
  assign pos_dec = pos_r - CW'(1);
  assign ord_ra  = cmd.em_ord_rd ? k_r : pos_dec[IW-1:0];
  assign ord_wa  = pos_r[IW-1:0];
  assign ord_wd  = cmd.place ? new_idx_r : ord_q_r;

  assign k_cnt      = CW'(k_r) + CW'(1);
  assign final_item = (k_cnt == count_r);
  assign cls        = classify(kind_q_r);
  assign idx_ext    = {{IDX_W{1'b0}}, ord_q_r};

  always_ff @(posedge clk) begin
    if (cmd.accept && !full) begin
      ue_mem[wr_idx]   <= ue_in;
      le_mem[wr_idx]   <= le_in;
      kind_mem[wr_idx] <= {in_lower_kind, in_upper_kind};
    end
    if (cmd.shift || cmd.place) begin
      ord_mem[ord_wa] <= ord_wd;
    end
    if (cmd.ord_rd || cmd.em_ord_rd) begin
      ord_q_r <= ord_mem[ord_ra];
    end
    if (cmd.rec_rd) begin
      ue_q_r <= ue_mem[ord_q_r];
      le_q_r <= le_mem[ord_q_r];
    end
    if (cmd.em_kind_rd) begin
      kind_q_r <= kind_mem[ord_q_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      new_ue_r  <= ue_in;
      new_le_r  <= le_in;
      new_idx_r <= wr_idx;
    end
    if (cmd.out_load) begin
      out_idx_r   <= idx_ext[IDX_W-1:0];
      out_class_r <= cls;
      out_end_r   <= final_item || (cls == CLASS_ERROR);
    end
  end

  always_comb begin
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    if (cmd.accept) begin
      pos_nxt  = count_r;
      last_nxt = in_last;
    end
    if (cmd.shift) begin
      pos_nxt = pos_dec;
    end
    if (cmd.place) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.next_item) begin
      k_nxt = k_r + IW'(1);
    end
    if (cmd.run_done) begin
      count_nxt = '0;
      pos_nxt   = '0;
      k_nxt     = '0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pos_r       <= '0;
      k_r         <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      k_r         <= k_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    st            = '0;
    st.full       = full;
    st.count_zero = (count_r == '0);
    st.pos_one    = (pos_r == CW'(1));
    st.new_first  = (new_ue_r > ue_q_r) || ((new_ue_r == ue_q_r) && (new_le_r > le_q_r));
    st.in_last    = in_last;
    st.last       = last_r;
    st.out_busy   = out_valid_r;
    st.out_taken  = out_valid_r && out_ready;
    st.run_end    = out_end_r;
  end

  assign out_valid        = out_valid_r;
  assign out_record_index = out_idx_r;
  assign out_pair_class   = out_class_r;
  assign out_run_end      = out_end_r;

  `ASSERT_IMPL(a_pos_in_range, clk, rst_n, 1'b1, pos_r <= count_r, "insert position past fill")
  `ASSERT_IMPL(a_emit_in_range, clk, rst_n, out_valid_r, k_cnt <= count_r, "emit past fill")
  `ASSERT_IMPL(a_error_ends_run, clk, rst_n, out_valid_r && out_class_r == CLASS_ERROR,
               out_end_r, "error word without run end")

endmodule

`default_nettype wire

>>> design/two_key_descending_sort_classify.sv
// two-key descending sort with pair class; each record is placed in the order list on load
// load: a record is dropped when the store is full, else compared with entries in turn
// (the entries it moves past, plus the one that stops the walk unless it reaches the front)
// emit: each result word is read out into one result register and held there until taken
// one record at a time, none taken while a run is being emitted
// reset (rst_n sync, active low) clears fill count and sequencer; stores are not cleared
`default_nettype none

module two_key_descending_sort_classify import tksc_pkg::*; #(
  parameter int MAX_RECORDS  = TKSC_MAX_RECORDS,
  parameter int ENERGY_WIDTH = TKSC_ENERGY_WIDTH
) (
  input wire logic    clk,
  input wire logic    rst_n,
  tksc_rec_if.sink    in_chan,
  tksc_res_if.source  out_chan
);

  cmd_t    cmd;
  status_t st;

  tksc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .st       (st),
    .cmd      (cmd)
  );

  tksc_dp #(
    .MAX_RECORDS  (MAX_RECORDS),
    .ENERGY_WIDTH (ENERGY_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_upper_energy  (in_chan.upper_energy),
    .in_lower_energy  (in_chan.lower_energy),
    .in_upper_kind    (in_chan.upper_kind),
    .in_lower_kind    (in_chan.lower_kind),
    .in_last          (in_chan.last),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_record_index (out_chan.record_index),
    .out_pair_class   (out_chan.pair_class),
    .out_run_end      (out_chan.run_end)
  );

endmodule

`default_nettype wire
